>>> hdl/msu_pkg.sv
// Shared types and constants of the multiplicative schedule update block.
// Used by every module of the block but msu_ram; depends on nothing.
package msu_pkg;

  localparam int NODE_W = 10;
  localparam int QDEPTH = 4;
  localparam int DIV_STEPS = 96;

  typedef enum logic [2:0] {
    K_MEMBER   = 3'd0,
    K_END_SET  = 3'd1,
    K_END_PASS = 3'd2,
    K_READ     = 3'd3,
    K_RESTART  = 3'd4
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SET_FULL  = 2'd1,
    ST_ZERO_NORM = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_THETA = 2'd0,
    CFG_NODES = 2'd1,
    CFG_PLEN  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [NODE_W-1:0]   node;
    logic                last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic [31:0] theta;
    logic [10:0] nodes;
    logic [31:0] plen;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [95:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    B_RST_DIV, B_RST_WAIT, B_CLEAR, B_IDLE, B_MEM_ADD, B_RD_WAIT,
    B_SET_MUL, B_SET_DEN, B_SET_DIV, B_SQ1, B_SQ2, B_SQ3, B_SQ4,
    B_MW_M, B_MW_W, B_MW_U, B_SET_FIN, B_PW_RD, B_PW_MH, B_PW_ML,
    B_PW_PROD, B_PW_DIV, B_PASS_ST, B_PASS_DIV, B_EMIT
  } back_state_t;

endpackage

>>> hdl/multiplicative_schedule_update_top.sv
// The back end runs input words one at a time. A set close walks the stored members, and
// a pass end walks every node in use, with a shorter second walk when the normalizer is
// zero; the shared 96-step divider and these memory walks set how long each word takes.
// Reset and restart run a pass that fills the memories; input words queue (up to four)
// meanwhile and config writes are taken.
module multiplicative_schedule_update_top import msu_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_SET = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_kind,
  input  logic [NODE_W-1:0] in_node,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       out_value,
  output logic [1:0]        out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  cfg_t     cfg_r;
  q_push_t  push;
  logic     q_full, q_valid, pop;
  cmd_t     q_cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.theta <= 32'd429497;
      cfg_r.nodes <= 11'd1024;
      cfg_r.plen <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THETA: cfg_r.theta <= cfg_data;
        CFG_NODES: cfg_r.nodes <= cfg_data[10:0];
        CFG_PLEN:  cfg_r.plen <= cfg_data;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  msu_front u_front (
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_node(in_node), .in_last(in_last), .q_full(q_full), .push(push)
  );

  msu_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .full(q_full),
    .pop(pop), .q_valid(q_valid), .q_cmd(q_cmd)
  );

  msu_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
  );

  msu_back #(.MAX_NODES(MAX_NODES), .MAX_SET(MAX_SET)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_cmd(q_cmd),
    .pop(pop), .div_req(div_req), .div_rsp(div_rsp), .out_valid(out_valid),
    .out_stall(out_stall), .out_value(out_value), .out_status(out_status)
  );

endmodule

>>> hdl/msu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module msu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/msu_front.sv
// Front end: accepts input words, drops unknown kinds and pushes commands.
// Depends on msu_pkg.
module msu_front import msu_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_kind,
  input  logic [NODE_W-1:0] in_node,
  input  logic              in_last,
  input  logic              q_full,
  output q_push_t           push
);

  logic kind_ok;

  assign kind_ok = (in_kind == K_MEMBER) || (in_kind == K_END_SET) ||
                   (in_kind == K_END_PASS) || (in_kind == K_READ) ||
                   (in_kind == K_RESTART);
  assign in_stall = q_full;
  assign push.valid = in_valid && !q_full && kind_ok;
  assign push.cmd.kind = cmd_kind_t'(in_kind);
  assign push.cmd.node = in_node;
  assign push.cmd.last = in_last;

endmodule

>>> hdl/msu_queue.sv
// Short command queue between the front end and the back end.
// Depends on msu_pkg.
module msu_queue import msu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t push,
  output logic    full,
  input  logic    pop,
  output logic    q_valid,
  output cmd_t    q_cmd
);

  localparam int PW = $clog2(QDEPTH);

  cmd_t            mem_r [QDEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r, cnt_nxt;

  assign full = (cnt_r == (PW+1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !(pop && q_valid)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push.valid && pop && q_valid) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop && q_valid) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wp_r] <= push.cmd;
    end
  end

endmodule

>>> hdl/msu_div.sv
// Shared restoring divider, one quotient bit per cycle over a 96-bit dividend.
// Depends on msu_pkg.
module msu_div import msu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy_r, done_r;
  logic [6:0]  cnt_r;
  logic [63:0] rem_r, dvs_r;
  logic [95:0] dvd_r;
  logic [64:0] rem_sh, diff;
  logic        ge;

  assign rem_sh = {rem_r, dvd_r[95]};
  assign ge = (rem_sh >= {1'b0, dvs_r});
  assign diff = rem_sh - {1'b0, dvs_r};
  assign rsp.done = done_r;
  assign rsp.quot = dvd_r[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        rem_r <= ge ? diff[63:0] : rem_sh[63:0];
        dvd_r <= {dvd_r[94:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 7'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        dvd_r <= req.dividend;
        dvs_r <= req.divisor;
      end
    end
  end

endmodule

>>> hdl/msu_back.sv
// Back end: sequencer over the probability, weight and member memories,
// with one shared multiplier and the output register. Depends on msu_pkg,
// msu_ram and an external msu_div.
module msu_back import msu_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_SET = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        pop,
  output div_req_t    div_req,
  input  div_rsp_t    div_rsp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value,
  output logic [1:0]  out_status
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int AW = $clog2(MAX_NODES + 1);
  localparam int CW = $clog2(MAX_SET + 1);
  localparam int MW = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
  localparam logic [32:0] ONE = 33'h1_0000_0000;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  back_state_t state_r, state_nxt;
  logic [AW-1:0] active_r, active_nxt, i_r, i_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, j_r, j_nxt;
  logic [32:0]   sum_r, sum_nxt, u_r, u_nxt, p_r, p_nxt;
  logic [63:0]   cost_r, cost_nxt, norm_r, norm_nxt, t_r, t_nxt, t2_r, t2_nxt;
  logic [63:0]   acc_r, acc_nxt, w_r, w_nxt, s_r, s_nxt, em_val_r, em_val_nxt;
  status_t       st_r, st_nxt, em_st_r, em_st_nxt, out_st_r, out_st_nxt;
  logic          last_r, last_nxt, pass2_r, pass2_nxt;
  logic [NW-1:0] node_r, node_nxt, mnode_r, mnode_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_value_r, out_value_nxt;
  logic [64:0]   mul_p_r;
  logic [32:0]   op_a;
  logic [31:0]   op_b;
  logic          adv;

  logic          p_we, w_we, m_we;
  logic [NW-1:0] p_waddr, p_raddr, w_waddr, w_raddr;
  logic [MW-1:0] m_waddr, m_raddr;
  logic [32:0]   p_wdata, p_rdata;
  logic [63:0]   w_wdata, w_rdata;
  logic [NW-1:0] m_wdata, m_rdata;

  logic [32:0] d, den;
  logic [31:0] x, nsel;
  logic [33:0] sum34;
  logic [63:0] prod;
  logic        in_range;

  msu_ram #(.WIDTH(33), .DEPTH(MAX_NODES)) u_prob (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );
  msu_ram #(.WIDTH(64), .DEPTH(MAX_NODES)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );
  msu_ram #(.WIDTH(NW), .DEPTH(MAX_SET)) u_members (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  assign d = ONE - sum_r;
  assign x = d[32] ? cfg.theta : mul_p_r[63:32];
  assign den = ONE - {1'b0, x};
  assign sum34 = {1'b0, sum_r} + {1'b0, p_rdata};
  assign prod = sat_add(s_r, {31'b0, mul_p_r[64:32]});
  assign in_range = (32'(q_cmd.node) < 32'(active_r));
  assign nsel = (cfg.nodes == '0) ? 32'd1 :
                ((32'(cfg.nodes) > 32'(MAX_NODES)) ? 32'(MAX_NODES) : 32'(cfg.nodes));

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_status = out_st_r;

  always_comb begin
    state_nxt = state_r;
    active_nxt = active_r;
    i_nxt = i_r;
    cnt_nxt = cnt_r;
    j_nxt = j_r;
    sum_nxt = sum_r;
    u_nxt = u_r;
    p_nxt = p_r;
    cost_nxt = cost_r;
    norm_nxt = norm_r;
    t_nxt = t_r;
    t2_nxt = t2_r;
    acc_nxt = acc_r;
    w_nxt = w_r;
    s_nxt = s_r;
    em_val_nxt = em_val_r;
    st_nxt = st_r;
    em_st_nxt = em_st_r;
    out_st_nxt = out_st_r;
    last_nxt = last_r;
    pass2_nxt = pass2_r;
    node_nxt = node_r;
    mnode_nxt = mnode_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    op_a = '0;
    op_b = '0;
    adv = 1'b0;
    pop = 1'b0;
    div_req.start = 1'b0;
    div_req.dividend = '0;
    div_req.divisor = '0;
    p_we = 1'b0;
    p_waddr = i_r[NW-1:0];
    p_wdata = u_r;
    p_raddr = i_r[NW-1:0];
    w_we = 1'b0;
    w_waddr = i_r[NW-1:0];
    w_wdata = '0;
    w_raddr = i_r[NW-1:0];
    m_we = 1'b0;
    m_waddr = cnt_r[MW-1:0];
    m_wdata = node_r;
    m_raddr = j_r[MW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      B_RST_DIV: begin
        active_nxt = AW'(nsel);
        div_req.start = 1'b1;
        div_req.dividend = 96'h1_0000_0000;
        div_req.divisor = 64'(nsel);
        state_nxt = B_RST_WAIT;
      end
      B_RST_WAIT: begin
        if (div_rsp.done) begin
          u_nxt = div_rsp.quot[32:0];
          i_nxt = '0;
          state_nxt = B_CLEAR;
        end
      end
      B_CLEAR: begin
        p_we = 1'b1;
        w_we = 1'b1;
        if (32'(i_r) == MAX_NODES - 1) begin
          cnt_nxt = '0;
          sum_nxt = '0;
          cost_nxt = '0;
          norm_nxt = '0;
          state_nxt = B_IDLE;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      B_IDLE: begin
        p_raddr = NW'(q_cmd.node);
        if (q_valid) begin
          pop = 1'b1;
          node_nxt = NW'(q_cmd.node);
          last_nxt = q_cmd.last;
          st_nxt = ST_OK;
          case (q_cmd.kind)
            K_MEMBER: begin
              if (!in_range || (32'(cnt_r) >= MAX_SET)) begin
                st_nxt = in_range ? ST_SET_FULL : ST_RANGE;
                if (q_cmd.last) begin
                  state_nxt = B_SET_MUL;
                end else begin
                  em_val_nxt = '0;
                  em_st_nxt = in_range ? ST_SET_FULL : ST_RANGE;
                  state_nxt = B_EMIT;
                end
              end else begin
                state_nxt = B_MEM_ADD;
              end
            end
            K_END_SET: state_nxt = B_SET_MUL;
            K_END_PASS: begin
              cnt_nxt = '0;
              sum_nxt = '0;
              norm_nxt = '0;
              i_nxt = '0;
              pass2_nxt = 1'b0;
              state_nxt = B_PW_RD;
            end
            K_READ: begin
              if (in_range) begin
                state_nxt = B_RD_WAIT;
              end else begin
                em_val_nxt = '0;
                em_st_nxt = ST_RANGE;
                state_nxt = B_EMIT;
              end
            end
            K_RESTART: state_nxt = B_RST_DIV;
            default: state_nxt = B_IDLE;
          endcase
        end
      end
      B_MEM_ADD: begin
        sum_nxt = (sum34 > {1'b0, ONE}) ? ONE : sum34[32:0];
        m_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = last_r ? B_SET_MUL : B_IDLE;
      end
      B_RD_WAIT: begin
        em_val_nxt = {31'b0, p_rdata};
        em_st_nxt = ST_OK;
        state_nxt = B_EMIT;
      end
      B_SET_MUL: begin
        op_a = {1'b0, cfg.theta};
        op_b = d[31:0];
        state_nxt = B_SET_DEN;
      end
      B_SET_DEN: begin
        if (den <= 33'd1) begin
          t_nxt = '1;
          state_nxt = B_SQ1;
        end else begin
          div_req.start = 1'b1;
          div_req.dividend = 96'h1_0000_0000_0000_0000;
          div_req.divisor = {31'b0, den};
          state_nxt = B_SET_DIV;
        end
      end
      B_SET_DIV: begin
        if (div_rsp.done) begin
          t_nxt = div_rsp.quot;
          state_nxt = B_SQ1;
        end
      end
      B_SQ1: begin
        op_a = {1'b0, t_r[63:32]};
        op_b = t_r[63:32];
        state_nxt = B_SQ2;
      end
      B_SQ2: begin
        acc_nxt = {mul_p_r[31:0], 32'b0};
        op_a = {1'b0, t_r[63:32]};
        op_b = t_r[31:0];
        state_nxt = B_SQ3;
      end
      B_SQ3: begin
        acc_nxt = sat_add(acc_r, {mul_p_r[62:0], 1'b0});
        op_a = {1'b0, t_r[31:0]};
        op_b = t_r[31:0];
        state_nxt = B_SQ4;
      end
      B_SQ4: begin
        t2_nxt = (t_r[63:48] != '0) ? '1 : sat_add(acc_r, {32'b0, mul_p_r[63:32]});
        cost_nxt = sat_add(cost_r, t_r);
        j_nxt = '0;
        state_nxt = (cnt_r == '0) ? B_SET_FIN : B_MW_M;
      end
      B_MW_M: state_nxt = B_MW_W;
      B_MW_W: begin
        w_raddr = m_rdata;
        mnode_nxt = m_rdata;
        state_nxt = B_MW_U;
      end
      B_MW_U: begin
        w_we = 1'b1;
        w_waddr = mnode_r;
        w_wdata = sat_add(w_rdata, t2_r);
        j_nxt = j_r + 1'b1;
        state_nxt = (32'(j_r) + 1 == 32'(cnt_r)) ? B_SET_FIN : B_MW_M;
      end
      B_SET_FIN: begin
        cnt_nxt = '0;
        sum_nxt = '0;
        em_val_nxt = t_r;
        em_st_nxt = st_r;
        state_nxt = B_EMIT;
      end
      B_PW_RD: begin
        if (pass2_r && (norm_r == '0)) begin
          w_we = 1'b1;
          adv = 1'b1;
        end else begin
          state_nxt = B_PW_MH;
        end
      end
      B_PW_MH: begin
        p_nxt = p_rdata;
        w_nxt = w_rdata;
        op_a = p_rdata;
        op_b = w_rdata[63:32];
        state_nxt = B_PW_ML;
      end
      B_PW_ML: begin
        s_nxt = mul_p_r[63:0];
        op_a = p_r;
        op_b = w_r[31:0];
        state_nxt = B_PW_PROD;
      end
      B_PW_PROD: begin
        if (!pass2_r) begin
          norm_nxt = sat_add(norm_r, prod);
          adv = 1'b1;
        end else begin
          div_req.start = 1'b1;
          div_req.dividend = {prod, 32'b0};
          div_req.divisor = norm_r;
          state_nxt = B_PW_DIV;
        end
      end
      B_PW_DIV: begin
        if (div_rsp.done) begin
          p_we = 1'b1;
          p_wdata = div_rsp.quot[32:0];
          w_we = 1'b1;
          adv = 1'b1;
        end
      end
      B_PASS_ST: begin
        div_req.start = 1'b1;
        div_req.dividend = {32'b0, cost_r};
        div_req.divisor = (cfg.plen == '0) ? 64'd1 : {32'b0, cfg.plen};
        state_nxt = B_PASS_DIV;
      end
      B_PASS_DIV: begin
        if (div_rsp.done) begin
          em_val_nxt = div_rsp.quot;
          em_st_nxt = (norm_r == '0) ? ST_ZERO_NORM : ST_OK;
          cost_nxt = '0;
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = em_val_r;
          out_st_nxt = em_st_r;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase

    if (adv) begin
      if (32'(i_r) == 32'(active_r) - 1) begin
        i_nxt = '0;
        if (!pass2_r) begin
          pass2_nxt = 1'b1;
          state_nxt = B_PW_RD;
        end else begin
          state_nxt = B_PASS_ST;
        end
      end else begin
        i_nxt = i_r + 1'b1;
        state_nxt = B_PW_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_RST_DIV;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
      sum_r <= '0;
      cost_r <= '0;
      norm_r <= '0;
      pass2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      cost_r <= cost_nxt;
      norm_r <= norm_nxt;
      pass2_r <= pass2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    active_r <= active_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    u_r <= u_nxt;
    p_r <= p_nxt;
    t_r <= t_nxt;
    t2_r <= t2_nxt;
    acc_r <= acc_nxt;
    w_r <= w_nxt;
    s_r <= s_nxt;
    em_val_r <= em_val_nxt;
    st_r <= st_nxt;
    em_st_r <= em_st_nxt;
    out_st_r <= out_st_nxt;
    last_r <= last_nxt;
    node_r <= node_nxt;
    mnode_r <= mnode_nxt;
    out_value_r <= out_value_nxt;
    mul_p_r <= op_a * op_b;
  end

endmodule
